@@ src/sorted_priority_queue_core_assert.svh @@
// Assertion macros for the sorted priority queue.
// SPQ_ASSERT expects clk and rst_n in the enclosing scope, SPQ_ASSERT_ALWAYS only clk.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/spq_pkg.sv @@
package spq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ITEM_DATA_W = 32;
  localparam int PRIO_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int FILL_W      = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  typedef logic signed [PRIO_W-1:0] prio_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic  push;
    logic  pop;
    prio_t prio;
  } cell_ctrl_t;

endpackage

@@ src/sorted_priority_queue_core.sv @@
// Sorted priority queue, DEPTH entries held in a chain of cells, highest
// priority at the head (cell 0).
// Input channel (in_valid/in_ready): in_op selects push or pop; a push
// stores in_item_data with signed priority in_item_priority behind every
// entry of equal or higher priority. A pop removes the head entry.
// Result channel (out_valid/out_ready): one result per item, giving the
// popped data word (zero on push or failed pop), a status code (ok, pop
// on empty, push dropped when full) and the fill level after the item.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle unless a low out_ready holds the result; every
// cell compares and shifts in the same cycle, so the rate does not depend on DEPTH.
// The result register holds its item while out_ready is low; in_ready
// stays high when that register is empty or being emptied in that cycle.
// Reset empties the queue and drops any pending result; entry payloads
// are not cleared, only the per-cell valid flags.
`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core #(
  parameter int DEPTH      = spq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [spq_pkg::ITEM_DATA_W-1:0] in_item_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_item_priority,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spq_pkg::ITEM_DATA_W-1:0] out_pop_data,
  output logic [spq_pkg::STATUS_W-1:0]    out_status,
  output logic [spq_pkg::FILL_W-1:0]      out_fill
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                  valid_vec [DEPTH];
  logic [DEPTH-1:0]      valid_bits;
  logic                  keep_vec  [DEPTH];
  logic [DATA_WIDTH-1:0] data_arr  [DEPTH];
  spq_pkg::prio_t        prio_arr  [DEPTH];

  logic                  p_keep  [DEPTH];
  logic                  p_valid [DEPTH];
  logic [DATA_WIDTH-1:0] p_data  [DEPTH];
  spq_pkg::prio_t        p_prio  [DEPTH];
  logic                  n_valid [DEPTH];
  logic [DATA_WIDTH-1:0] n_data  [DEPTH];
  spq_pkg::prio_t        n_prio  [DEPTH];

  spq_pkg::cell_ctrl_t   ctrl;
  logic [DATA_WIDTH-1:0] new_data;

  logic                  accept, full, empty, do_push, do_pop;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r;
  logic [spq_pkg::ITEM_DATA_W-1:0] out_pop_data_r, pop_data_nxt;
  spq_pkg::status_t      out_status_r, status_nxt;
  logic [spq_pkg::FILL_W-1:0] out_fill_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = valid_vec[DEPTH-1];
  assign empty    = !valid_vec[0];
  assign do_push  = accept && (in_op == spq_pkg::OP_PUSH) && !full;
  assign do_pop   = accept && (in_op == spq_pkg::OP_POP) && !empty;

  assign ctrl.push = do_push;
  assign ctrl.pop  = do_pop;
  assign ctrl.prio = in_item_priority;
  assign new_data  = DATA_WIDTH'(in_item_data);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign p_keep[g]  = 1'b1;
      assign p_valid[g] = 1'b0;
      assign p_data[g]  = '0;
      assign p_prio[g]  = '0;
    end else begin : g_mid
      assign p_keep[g]  = keep_vec[g-1];
      assign p_valid[g] = valid_vec[g-1];
      assign p_data[g]  = data_arr[g-1];
      assign p_prio[g]  = prio_arr[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign n_valid[g] = 1'b0;
      assign n_data[g]  = '0;
      assign n_prio[g]  = '0;
    end else begin : g_body
      assign n_valid[g] = valid_vec[g+1];
      assign n_data[g]  = data_arr[g+1];
      assign n_prio[g]  = prio_arr[g+1];
    end

    spq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_data  (new_data),
      .prev_keep (p_keep[g]),
      .prev_valid(p_valid[g]),
      .prev_data (p_data[g]),
      .prev_prio (p_prio[g]),
      .next_valid(n_valid[g]),
      .next_data (n_data[g]),
      .next_prio (n_prio[g]),
      .valid     (valid_vec[g]),
      .data      (data_arr[g]),
      .prio      (prio_arr[g]),
      .keep      (keep_vec[g])
    );

    assign valid_bits[g] = valid_vec[g];
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    pop_data_nxt = '0;
    status_nxt   = spq_pkg::STATUS_OK;
    if (in_op == spq_pkg::OP_PUSH) begin
      if (full) begin
        status_nxt = spq_pkg::STATUS_FULL;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = spq_pkg::STATUS_EMPTY;
      end else begin
        pop_data_nxt = spq_pkg::ITEM_DATA_W'(data_arr[0]);
        cnt_nxt      = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pop_data_r <= pop_data_nxt;
      out_status_r   <= status_nxt;
      out_fill_r     <= spq_pkg::FILL_W'(cnt_nxt);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pop_data = out_pop_data_r;
  assign out_status   = out_status_r;
  assign out_fill     = out_fill_r;

  `SPQ_ASSERT(a_cnt_matches_cells, ($countones(valid_bits) == cnt_r), "count out of step with cells")
  `SPQ_ASSERT(a_cells_packed, ((valid_bits & (valid_bits + DEPTH'(1))) == '0), "gap in cell chain")
  `SPQ_ASSERT(a_empty_pop_status, (accept && in_op == spq_pkg::OP_POP && empty |=> out_status_r == spq_pkg::STATUS_EMPTY && out_pop_data_r == '0), "pop on empty misreported")
  `SPQ_ASSERT(a_full_push_hold, (accept && in_op == spq_pkg::OP_PUSH && full |=> cnt_r == $past(cnt_r) && out_status_r == spq_pkg::STATUS_FULL), "push on full changed queue")
  `SPQ_ASSERT_ALWAYS(a_reset_clears, (!rst_n |=> !out_valid_r && cnt_r == '0), "reset left queue state")

endmodule

@@ src/spq_cell.sv @@
module spq_cell #(
  parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spq_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0] new_data,
  input  logic                  prev_keep,
  input  logic                  prev_valid,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  spq_pkg::prio_t        prev_prio,
  input  logic                  next_valid,
  input  logic [DATA_WIDTH-1:0] next_data,
  input  spq_pkg::prio_t        next_prio,
  output logic                  valid,
  output logic [DATA_WIDTH-1:0] data,
  output spq_pkg::prio_t        prio,
  output logic                  keep
);

  logic                  valid_r, valid_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  spq_pkg::prio_t        prio_r, prio_nxt;

  // entry stays put on a push unless the new item outranks it
  assign keep = valid_r && !(prio_r < ctrl.prio);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    prio_nxt  = prio_r;
    if (ctrl.push) begin
      if (!keep) begin
        if (prev_keep) begin
          valid_nxt = 1'b1;
          data_nxt  = new_data;
          prio_nxt  = ctrl.prio;
        end else begin
          valid_nxt = prev_valid;
          data_nxt  = prev_data;
          prio_nxt  = prev_prio;
        end
      end
    end else if (ctrl.pop) begin
      valid_nxt = next_valid;
      data_nxt  = next_data;
      prio_nxt  = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;
  assign prio  = prio_r;

endmodule
